// ----- hdl/tasa_pkg.sv -----
// Shared constants, codes and divider handshake types for the texture atlas slab allocator.
package tasa_pkg;

    // Default sizes of the page, slot and handle stores
    localparam int DEF_MAX_PAGES   = 64;
    localparam int DEF_MAX_SLOTS   = 256;
    localparam int DEF_MAX_HANDLES = 1024;

    // Field widths
    localparam int DIM_W    = 13;
    localparam int FMT_W    = 4;
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 10;
    localparam int STATUS_W = 3;
    localparam int ORG_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Divider operand width and its step counter width
    localparam int DVW   = 13;
    localparam int DCNTW = $clog2(DVW + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RSVD_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RSVD_H   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 3'd6;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_ATLAS_DIM = 13'd1024;
    localparam logic [DIM_W-1:0] RST_PAGE_DIM  = 13'd256;
    localparam logic [DIM_W-1:0] RST_RSVD_DIM  = 13'd0;
    localparam logic [FMT_W-1:0] RST_FORMAT    = 4'd0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_BIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNBIND = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_ALL    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISFIT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd5;

    // Size reported for an unbound handle
    localparam logic [DIM_W-1:0] UNBOUND_SIZE = 13'd4;

    typedef struct packed {
        logic           start;
        logic [DVW-1:0] num;
        logic [DVW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [DVW-1:0] quo;
        logic [DVW-1:0] rem;
    } div_rsp_t;

endpackage

// ----- hdl/tasa_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tasa_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tasa_pkg::div_req_t req,
    output tasa_pkg::div_rsp_t rsp
);
    import tasa_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DCNTW-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   quo_reg, quo_next;
    logic [DVW-1:0]   den_reg, den_next;
    logic [DVW+1:0]   diff;
    logic             neg;

    // Trial subtraction of the divisor from the shifted partial remainder
    assign diff = {1'b0, rem_reg, quo_reg[DVW-1]} - {2'b00, den_reg};
    assign neg  = diff[DVW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNTW'(DVW);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = neg ? {rem_reg[DVW-2:0], quo_reg[DVW-1]} : diff[DVW-1:0];
            quo_next = {quo_reg[DVW-2:0], ~neg};
            cnt_next = cnt_reg - DCNTW'(1);
            if (cnt_reg == DCNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hdl/texture_atlas_slab_allocator.sv -----
// Top level: slab allocator of texture slots over a paged atlas.
//
// Usage: write the seven atlas registers on the cfg port (cfg_write, cfg_index,
// cfg_data). Every write, and reset, rebuilds the free-page stack and drops all
// bindings; the rebuild takes 3 divisions, then walks each atlas row and each
// kept page, and in_stall is high meanwhile.
// Requests arrive on in_valid/in_stall, one item at a time; the block takes a
// new item only when the sequencer is idle. Each item gives one result item on
// out_valid/out_stall, held in an output register.
// Work per item:
//   lookup  two shared divider passes for the slot origin
//   bind    a scan of the active pages, two more divisions when a new page is opened
//   unbind  a walk of the active page list when a page is retired
//   unbind all: the unbind work for each handle issued
// The shared 13-bit divider and the state memories, one read port each, set this
// work. A stalled result holds; the next item may be accepted meanwhile but
// its result waits in the sequencer until the output register frees up.
module texture_atlas_slab_allocator #(
    parameter int MAX_PAGES   = tasa_pkg::DEF_MAX_PAGES,
    parameter int MAX_SLOTS   = tasa_pkg::DEF_MAX_SLOTS,
    parameter int MAX_HANDLES = tasa_pkg::DEF_MAX_HANDLES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tasa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tasa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tasa_pkg::OP_W-1:0]         op,
    input  logic [tasa_pkg::DIM_W-1:0]        tex_width,
    input  logic [tasa_pkg::DIM_W-1:0]        tex_height,
    input  logic [tasa_pkg::FMT_W-1:0]        tex_format,
    input  logic [tasa_pkg::HANDLE_W-1:0]     handle,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tasa_pkg::STATUS_W-1:0]     status,
    output logic [tasa_pkg::HANDLE_W-1:0]     out_handle,
    output logic [tasa_pkg::ORG_W-1:0]        origin_x,
    output logic [tasa_pkg::ORG_W-1:0]        origin_y,
    output logic [tasa_pkg::DIM_W-1:0]        slot_width,
    output logic [tasa_pkg::DIM_W-1:0]        slot_height
);
    import tasa_pkg::*;

    localparam int PW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW    = $clog2(MAX_PAGES + 1);
    localparam int SLW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCW    = $clog2(MAX_SLOTS + 1);
    localparam int HIW    = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam int HCW    = $clog2(MAX_HANDLES + 1);
    localparam int HXW    = (HCW > HANDLE_W) ? HCW : HANDLE_W;
    localparam int SDEPTH = MAX_PAGES << SLW;
    localparam int PRW    = 2 * DVW;
    localparam int NS     = 36;

    typedef struct packed {
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
        logic [SCW-1:0]   total;
        logic [SCW-1:0]   free;
        logic [SCW-1:0]   mark;
    } page_rec_t;

    typedef struct packed {
        logic           vld;
        logic [PW-1:0]  page;
        logic [SLW-1:0] slot;
    } hdl_ent_t;

    typedef enum logic [NS-1:0] {
        S_IDLE    = NS'(1) << 0,
        S_RB_INIT = NS'(1) << 1,
        S_RB_XP   = NS'(1) << 2,
        S_RB_YP   = NS'(1) << 3,
        S_RB_SK   = NS'(1) << 4,
        S_RB_ROW  = NS'(1) << 5,
        S_RB_COL  = NS'(1) << 6,
        S_B_SCAN  = NS'(1) << 7,
        S_B_SC1   = NS'(1) << 8,
        S_B_SC2   = NS'(1) << 9,
        S_B_NEW   = NS'(1) << 10,
        S_B_N1    = NS'(1) << 11,
        S_B_N2    = NS'(1) << 12,
        S_B_N3    = NS'(1) << 13,
        S_B_HCHK  = NS'(1) << 14,
        S_B_POP   = NS'(1) << 15,
        S_B_SLOT  = NS'(1) << 16,
        S_B_SL1   = NS'(1) << 17,
        S_ORG     = NS'(1) << 18,
        S_OG1     = NS'(1) << 19,
        S_OG2     = NS'(1) << 20,
        S_OG3     = NS'(1) << 21,
        S_OG4     = NS'(1) << 22,
        S_L_CHK   = NS'(1) << 23,
        S_L_1     = NS'(1) << 24,
        S_L_2     = NS'(1) << 25,
        S_U_CHK   = NS'(1) << 26,
        S_U_1     = NS'(1) << 27,
        S_U_2     = NS'(1) << 28,
        S_U_RM    = NS'(1) << 29,
        S_U_RM1   = NS'(1) << 30,
        S_U_SH    = NS'(1) << 31,
        S_U_SH1   = NS'(1) << 32,
        S_U_END   = NS'(1) << 33,
        S_A_NEXT  = NS'(1) << 34,
        S_DONE    = NS'(1) << 35
    } state_t;

    // Configuration registers
    logic [DIM_W-1:0] aw_reg, ah_reg, pw_reg, ph_reg, rw_reg, rh_reg;
    logic [FMT_W-1:0] fmt_reg;
    logic             cfg_hit;

    // Control state
    state_t          state_reg, state_next;
    logic [PCW-1:0]  fpc_reg, fpc_next;
    logic [PCW-1:0]  apc_reg, apc_next;
    logic [HCW-1:0]  issued_reg, issued_next;
    logic [HCW-1:0]  fhc_reg, fhc_next;
    logic            out_valid_reg, out_valid_next;

    // Working registers
    logic [OP_W-1:0]     op_reg, op_next;
    logic [DIM_W-1:0]    tw_reg, tw_next, th_reg, th_next;
    logic [HXW-1:0]      h_reg, h_next;
    logic [PCW-1:0]      k_reg, k_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [SLW-1:0]      slot_reg, slot_next;
    logic [DVW-1:0]      q2_reg, q2_next;
    logic                found_reg, found_next;
    logic [SCW-1:0]      n_reg, n_next;
    page_rec_t           pr_reg, pr_next;
    logic [DIM_W-1:0]    xp_reg, xp_next, yp_reg, yp_next, skip_reg, skip_next;
    logic [DIM_W-1:0]    i_reg, i_next, j_reg, j_next, ox_reg, ox_next, oy_reg, oy_next;
    logic [DVW-1:0]      mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [PRW-1:0]      mul_p;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic [HANDLE_W-1:0] res_h_reg, res_h_next;
    logic [ORG_W-1:0]    res_ox_reg, res_ox_next, res_oy_reg, res_oy_next;
    logic [DIM_W-1:0]    res_sw_reg, res_sw_next, res_sh_reg, res_sh_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [HANDLE_W-1:0] oh_reg, oh_next;
    logic [ORG_W-1:0]    ox_out_reg, ox_out_next, oy_out_reg, oy_out_next;
    logic [DIM_W-1:0]    sw_reg, sw_next, sh_reg, sh_next;

    // Memories and their ports
    logic [PW-1:0]     fps_mem [MAX_PAGES];
    logic [PW-1:0]     apl_mem [MAX_PAGES];
    logic [2*ORG_W-1:0] org_mem [MAX_PAGES];
    page_rec_t         pg_mem  [MAX_PAGES];
    logic [SLW-1:0]    slot_mem [SDEPTH];
    hdl_ent_t          hdl_mem [MAX_HANDLES];
    logic [HIW-1:0]    fhs_mem [MAX_HANDLES];

    logic [PW-1:0]      fps_rd_reg, apl_rd_reg;
    logic [2*ORG_W-1:0] org_rd_reg;
    page_rec_t          pg_rd_reg;
    logic [SLW-1:0]     slot_rd_reg;
    hdl_ent_t           hdl_rd_reg;
    logic [HIW-1:0]     fhs_rd_reg;

    logic                fps_we, apl_we, org_we, pg_we, slot_we, hdl_we, fhs_we;
    logic [PW-1:0]       fps_wa, apl_wa, org_wa, apl_ra, pg_ra;
    logic [PW-1:0]       fps_wd, apl_wd;
    logic [2*ORG_W-1:0]  org_wd;
    page_rec_t           pg_wd;
    logic [SLW-1:0]      slot_wd;
    logic [PW+SLW-1:0]   slot_wa, slot_ra;
    hdl_ent_t            hdl_wd;
    logic [HIW-1:0]      fhs_wa, fhs_wd;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Scratch values
    logic [DIM_W:0]   skip_w;
    logic [SCW-1:0]   sl_idx, sl_free;
    logic             take, misfit, lower;

    tasa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign mul_p    = mul_a_reg * mul_b_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign take     = out_valid_reg && !out_stall;
    assign misfit   = (tex_width == '0) || (tex_height == '0) || (tex_format != fmt_reg)
                      || (tex_width > pw_reg) || (tex_height > ph_reg);
    assign cfg_hit  = cfg_write && (cfg_index <= REG_FORMAT);
    assign skip_w   = {1'b0, div_rsp.quo} + {{DIM_W{1'b0}}, (div_rsp.rem != '0)};
    assign lower    = (oy_reg < rh_reg);
    assign sl_idx   = pr_reg.free - SCW'(1);
    assign sl_free  = pg_rd_reg.free + SCW'(1);

    // Fixed read addresses
    assign slot_ra = {p_reg, sl_idx[SLW-1:0]};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        fpc_next    = fpc_reg;
        apc_next    = apc_reg;
        issued_next = issued_reg;
        fhc_next    = fhc_reg;
        out_valid_next = out_valid_reg && !take;
        op_next     = op_reg;
        tw_next     = tw_reg;
        th_next     = th_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        slot_next   = slot_reg;
        q2_next     = q2_reg;
        found_next  = found_reg;
        n_next      = n_reg;
        pr_next     = pr_reg;
        xp_next     = xp_reg;
        yp_next     = yp_reg;
        skip_next   = skip_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        mul_a_next  = mul_a_reg;
        mul_b_next  = mul_b_reg;
        res_st_next = res_st_reg;
        res_h_next  = res_h_reg;
        res_ox_next = res_ox_reg;
        res_oy_next = res_oy_reg;
        res_sw_next = res_sw_reg;
        res_sh_next = res_sh_reg;
        st_next     = st_reg;
        oh_next     = oh_reg;
        ox_out_next = ox_out_reg;
        oy_out_next = oy_out_reg;
        sw_next     = sw_reg;
        sh_next     = sh_reg;
        div_req     = '0;
        fps_we  = 1'b0;  fps_wa  = PW'(fpc_reg);  fps_wd = PW'(fpc_reg);
        apl_we  = 1'b0;  apl_wa  = PW'(apc_reg);  apl_wd = p_reg;
        org_we  = 1'b0;  org_wa  = PW'(fpc_reg);  org_wd = {ox_reg[ORG_W-1:0], oy_reg[ORG_W-1:0]};
        pg_we   = 1'b0;  pg_wd   = pr_reg;
        slot_we = 1'b0;  slot_wa = {p_reg, pg_rd_reg.free[SLW-1:0]};  slot_wd = slot_reg;
        hdl_we  = 1'b0;  hdl_wd  = '{vld: 1'b1, page: p_reg, slot: slot_reg};
        fhs_we  = 1'b0;  fhs_wa  = HIW'(fhc_reg);  fhs_wd = h_reg[HIW-1:0];
        apl_ra  = PW'(k_reg);
        pg_ra   = hdl_rd_reg.page;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    tw_next     = tex_width;
                    th_next     = tex_height;
                    h_next      = HXW'(handle);
                    found_next  = 1'b0;
                    k_next      = '0;
                    res_st_next = ST_OK;
                    res_h_next  = '0;
                    res_ox_next = '0;
                    res_oy_next = '0;
                    res_sw_next = '0;
                    res_sh_next = '0;
                    case (op)
                        OP_BIND:
                        begin
                            if (misfit)
                            begin
                                res_st_next = ST_MISFIT;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_B_SCAN;
                        end
                        OP_UNBIND: state_next = S_U_CHK;
                        OP_LOOKUP: state_next = S_L_CHK;
                        default:
                        begin
                            h_next     = '0;
                            state_next = S_A_NEXT;
                        end
                    endcase
                end
            end

            // Rebuild of the free-page stack
            S_RB_INIT:
            begin
                fpc_next    = '0;
                apc_next    = '0;
                issued_next = '0;
                fhc_next    = '0;
                if (pw_reg == '0 || ph_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    div_req    = '{start: 1'b1, num: aw_reg, den: pw_reg};
                    state_next = S_RB_XP;
                end
            end
            S_RB_XP:
            begin
                if (div_rsp.done)
                begin
                    xp_next    = div_rsp.quo;
                    div_req    = '{start: 1'b1, num: ah_reg, den: ph_reg};
                    state_next = S_RB_YP;
                end
            end
            S_RB_YP:
            begin
                if (div_rsp.done)
                begin
                    yp_next    = div_rsp.quo;
                    div_req    = '{start: 1'b1, num: rw_reg, den: pw_reg};
                    state_next = S_RB_SK;
                end
            end
            S_RB_SK:
            begin
                if (div_rsp.done)
                begin
                    // Reserved columns rounded up, at most a full row
                    skip_next  = (skip_w > {1'b0, xp_reg}) ? xp_reg : skip_w[DIM_W-1:0];
                    mul_a_next = (skip_w > {1'b0, xp_reg}) ? xp_reg : skip_w[DIM_W-1:0];
                    mul_b_next = pw_reg;
                    i_next     = '0;
                    oy_next    = '0;
                    state_next = S_RB_ROW;
                end
            end
            S_RB_ROW:
            begin
                if (i_reg >= yp_reg || fpc_reg >= PCW'(MAX_PAGES))
                    state_next = S_IDLE;
                else
                begin
                    j_next     = lower ? skip_reg : '0;
                    ox_next    = lower ? mul_p[DIM_W-1:0] : '0;
                    state_next = S_RB_COL;
                end
            end
            S_RB_COL:
            begin
                if (j_reg >= xp_reg || fpc_reg >= PCW'(MAX_PAGES))
                begin
                    i_next     = i_reg + DIM_W'(1);
                    oy_next    = oy_reg + ph_reg;
                    state_next = S_RB_ROW;
                end
                else
                begin
                    fps_we   = 1'b1;
                    org_we   = 1'b1;
                    fpc_next = fpc_reg + PCW'(1);
                    j_next   = j_reg + DIM_W'(1);
                    ox_next  = ox_reg + pw_reg;
                end
            end

            // Bind: first-fit scan of the active pages
            S_B_SCAN:
            begin
                if (k_reg >= apc_reg)
                    state_next = S_B_NEW;
                else
                    state_next = S_B_SC1;
            end
            S_B_SC1:
            begin
                pg_ra      = apl_rd_reg;
                p_next     = apl_rd_reg;
                state_next = S_B_SC2;
            end
            S_B_SC2:
            begin
                if (pg_rd_reg.tw == tw_reg && pg_rd_reg.th == th_reg && pg_rd_reg.free != '0)
                begin
                    found_next = 1'b1;
                    pr_next    = pg_rd_reg;
                    state_next = S_B_HCHK;
                end
                else
                begin
                    k_next     = k_reg + PCW'(1);
                    state_next = S_B_SCAN;
                end
            end

            // Bind: slot count of a fresh page
            S_B_NEW:
            begin
                if (fpc_reg == '0)
                begin
                    res_st_next = ST_NO_PAGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_req    = '{start: 1'b1, num: pw_reg, den: tw_reg};
                    state_next = S_B_N1;
                end
            end
            S_B_N1:
            begin
                if (div_rsp.done)
                begin
                    mul_a_next = div_rsp.quo;
                    div_req    = '{start: 1'b1, num: ph_reg, den: th_reg};
                    state_next = S_B_N2;
                end
            end
            S_B_N2:
            begin
                if (div_rsp.done)
                begin
                    mul_b_next = div_rsp.quo;
                    state_next = S_B_N3;
                end
            end
            S_B_N3:
            begin
                n_next = SCW'(mul_p);
                if (mul_p > PRW'(MAX_SLOTS))
                begin
                    res_st_next = ST_TOO_MANY;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_B_HCHK;
            end
            S_B_HCHK:
            begin
                if (fhc_reg == '0 && issued_reg >= HCW'(MAX_HANDLES))
                begin
                    res_st_next = ST_NO_HANDLE;
                    state_next  = S_DONE;
                end
                else if (found_reg)
                    state_next = S_B_SLOT;
                else
                    state_next = S_B_POP;
            end
            S_B_POP:
            begin
                p_next      = fps_rd_reg;
                fpc_next    = fpc_reg - PCW'(1);
                pr_next     = '{tw: tw_reg, th: th_reg, total: n_reg, free: n_reg, mark: n_reg};
                apl_we      = 1'b1;
                apl_wd      = fps_rd_reg;
                apc_next    = apc_reg + PCW'(1);
                state_next  = S_B_SLOT;
            end
            S_B_SLOT:
            begin
                state_next = S_B_SL1;
            end
            S_B_SL1:
            begin
                // Slots below the low-water mark still hold their initial order
                if (sl_idx < pr_reg.mark)
                    slot_next = SLW'(pr_reg.total - SCW'(1) - sl_idx);
                else
                    slot_next = slot_rd_reg;
                pr_next.free = sl_idx;
                pr_next.mark = (sl_idx < pr_reg.mark) ? sl_idx : pr_reg.mark;
                pg_we = 1'b1;
                pg_wd = pr_next;
                if (fhc_reg != '0)
                begin
                    h_next   = HXW'(fhs_rd_reg);
                    fhc_next = fhc_reg - HCW'(1);
                end
                else
                begin
                    h_next      = HXW'(issued_reg);
                    issued_next = issued_reg + HCW'(1);
                end
                res_h_next = HANDLE_W'(h_next);
                state_next = S_ORG;
            end

            // Slot origin: row length, then slot column and row
            S_ORG:
            begin
                if (op_reg == OP_BIND)
                    hdl_we = 1'b1;
                div_req    = '{start: 1'b1, num: pw_reg, den: pr_reg.tw};
                state_next = S_OG1;
            end
            S_OG1:
            begin
                if (div_rsp.done)
                begin
                    div_req    = '{start: 1'b1, num: DVW'(slot_reg), den: div_rsp.quo};
                    state_next = S_OG2;
                end
            end
            S_OG2:
            begin
                if (div_rsp.done)
                begin
                    mul_a_next = div_rsp.rem;
                    mul_b_next = pr_reg.tw;
                    q2_next    = div_rsp.quo;
                    state_next = S_OG3;
                end
            end
            S_OG3:
            begin
                res_ox_next = mul_p[ORG_W-1:0] + org_rd_reg[2*ORG_W-1:ORG_W];
                mul_a_next  = q2_reg;
                mul_b_next  = pr_reg.th;
                state_next  = S_OG4;
            end
            S_OG4:
            begin
                res_oy_next = mul_p[ORG_W-1:0] + org_rd_reg[ORG_W-1:0];
                res_sw_next = pr_reg.tw;
                res_sh_next = pr_reg.th;
                state_next  = S_DONE;
            end

            // Lookup
            S_L_CHK:
            begin
                if (h_reg < HXW'(issued_reg) && h_reg < HXW'(MAX_HANDLES))
                    state_next = S_L_1;
                else
                begin
                    res_st_next = ST_BAD_HANDLE;
                    res_sw_next = UNBOUND_SIZE;
                    res_sh_next = UNBOUND_SIZE;
                    state_next  = S_DONE;
                end
            end
            S_L_1:
            begin
                p_next    = hdl_rd_reg.page;
                slot_next = hdl_rd_reg.slot;
                if (hdl_rd_reg.vld)
                    state_next = S_L_2;
                else
                begin
                    res_st_next = ST_BAD_HANDLE;
                    res_sw_next = UNBOUND_SIZE;
                    res_sh_next = UNBOUND_SIZE;
                    state_next  = S_DONE;
                end
            end
            S_L_2:
            begin
                pr_next    = pg_rd_reg;
                state_next = S_ORG;
            end

            // Unbind of one handle
            S_U_CHK:
            begin
                if (h_reg < HXW'(issued_reg) && h_reg < HXW'(MAX_HANDLES))
                    state_next = S_U_1;
                else
                begin
                    if (op_reg != OP_ALL)
                        res_st_next = ST_BAD_HANDLE;
                    state_next = S_U_END;
                end
            end
            S_U_1:
            begin
                p_next    = hdl_rd_reg.page;
                slot_next = hdl_rd_reg.slot;
                if (hdl_rd_reg.vld)
                    state_next = S_U_2;
                else
                begin
                    if (op_reg != OP_ALL)
                        res_st_next = ST_BAD_HANDLE;
                    state_next = S_U_END;
                end
            end
            S_U_2:
            begin
                slot_we  = 1'b1;
                fhs_we   = 1'b1;
                fhc_next = fhc_reg + HCW'(1);
                hdl_we   = 1'b1;
                hdl_wd   = '{vld: 1'b0, page: p_reg, slot: slot_reg};
                pg_we    = 1'b1;
                pg_wd    = pg_rd_reg;
                if (sl_free == pg_rd_reg.total)
                begin
                    // Last slot back: retire the page
                    pg_wd.total = '0;
                    pg_wd.free  = '0;
                    fps_we      = 1'b1;
                    fps_wd      = p_reg;
                    fpc_next    = fpc_reg + PCW'(1);
                    k_next      = '0;
                    state_next  = S_U_RM;
                end
                else
                begin
                    pg_wd.free = sl_free;
                    state_next = S_U_END;
                end
            end
            S_U_RM:
            begin
                if (k_reg >= apc_reg)
                    state_next = S_U_END;
                else
                    state_next = S_U_RM1;
            end
            S_U_RM1:
            begin
                if (apl_rd_reg == p_reg)
                    state_next = S_U_SH;
                else
                begin
                    k_next     = k_reg + PCW'(1);
                    state_next = S_U_RM;
                end
            end
            S_U_SH:
            begin
                apl_ra = PW'(k_reg + PCW'(1));
                if (k_reg + PCW'(1) >= apc_reg)
                begin
                    apc_next   = apc_reg - PCW'(1);
                    state_next = S_U_END;
                end
                else
                    state_next = S_U_SH1;
            end
            S_U_SH1:
            begin
                apl_we     = 1'b1;
                apl_wa     = PW'(k_reg);
                apl_wd     = apl_rd_reg;
                k_next     = k_reg + PCW'(1);
                state_next = S_U_SH;
            end
            S_U_END:
            begin
                if (op_reg == OP_ALL)
                begin
                    h_next     = h_reg + HXW'(1);
                    state_next = S_A_NEXT;
                end
                else
                    state_next = S_DONE;
            end

            // Unbind all: walk every issued handle
            S_A_NEXT:
            begin
                if (h_reg < HXW'(issued_reg))
                    state_next = S_U_CHK;
                else
                begin
                    res_st_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || take)
                begin
                    st_next        = res_st_reg;
                    oh_next        = res_h_reg;
                    ox_out_next    = res_ox_reg;
                    oy_out_next    = res_oy_reg;
                    sw_next        = res_sw_reg;
                    sh_next        = res_sh_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // A register write restarts the rebuild
        if (cfg_hit)
            state_next = S_RB_INIT;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg  <= RST_ATLAS_DIM;
            ah_reg  <= RST_ATLAS_DIM;
            pw_reg  <= RST_PAGE_DIM;
            ph_reg  <= RST_PAGE_DIM;
            rw_reg  <= RST_RSVD_DIM;
            rh_reg  <= RST_RSVD_DIM;
            fmt_reg <= RST_FORMAT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ATLAS_W: aw_reg  <= cfg_data;
                REG_ATLAS_H: ah_reg  <= cfg_data;
                REG_PAGE_W:  pw_reg  <= cfg_data;
                REG_PAGE_H:  ph_reg  <= cfg_data;
                REG_RSVD_W:  rw_reg  <= cfg_data;
                REG_RSVD_H:  rh_reg  <= cfg_data;
                REG_FORMAT:  fmt_reg <= cfg_data[FMT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RB_INIT;
            fpc_reg       <= '0;
            apc_reg       <= '0;
            issued_reg    <= '0;
            fhc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fpc_reg       <= fpc_next;
            apc_reg       <= apc_next;
            issued_reg    <= issued_next;
            fhc_reg       <= fhc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tw_reg     <= tw_next;
        th_reg     <= th_next;
        h_reg      <= h_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        slot_reg   <= slot_next;
        q2_reg     <= q2_next;
        found_reg  <= found_next;
        n_reg      <= n_next;
        pr_reg     <= pr_next;
        xp_reg     <= xp_next;
        yp_reg     <= yp_next;
        skip_reg   <= skip_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        res_st_reg <= res_st_next;
        res_h_reg  <= res_h_next;
        res_ox_reg <= res_ox_next;
        res_oy_reg <= res_oy_next;
        res_sw_reg <= res_sw_next;
        res_sh_reg <= res_sh_next;
        st_reg     <= st_next;
        oh_reg     <= oh_next;
        ox_out_reg <= ox_out_next;
        oy_out_reg <= oy_out_next;
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
    end

    // Free-page stack
    always_ff @(posedge clk)
    begin
        if (fps_we)
            fps_mem[fps_wa] <= fps_wd;
        fps_rd_reg <= fps_mem[PW'(fpc_reg - PCW'(1))];
    end

    // Active page list
    always_ff @(posedge clk)
    begin
        if (apl_we)
            apl_mem[apl_wa] <= apl_wd;
        apl_rd_reg <= apl_mem[apl_ra];
    end

    // Page origins
    always_ff @(posedge clk)
    begin
        if (org_we)
            org_mem[org_wa] <= org_wd;
        org_rd_reg <= org_mem[p_reg];
    end

    // Per-page slot size and counts
    always_ff @(posedge clk)
    begin
        if (pg_we)
            pg_mem[p_reg] <= pg_wd;
        pg_rd_reg <= pg_mem[pg_ra];
    end

    // Per-page free-slot stacks
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[slot_ra];
    end

    // Handle table
    always_ff @(posedge clk)
    begin
        if (hdl_we)
            hdl_mem[h_reg[HIW-1:0]] <= hdl_wd;
        hdl_rd_reg <= hdl_mem[h_reg[HIW-1:0]];
    end

    // Recycled handle stack
    always_ff @(posedge clk)
    begin
        if (fhs_we)
            fhs_mem[fhs_wa] <= fhs_wd;
        fhs_rd_reg <= fhs_mem[HIW'(fhc_reg - HCW'(1))];
    end

    assign out_valid   = out_valid_reg;
    assign status      = st_reg;
    assign out_handle  = oh_reg;
    assign origin_x    = ox_out_reg;
    assign origin_y    = oy_out_reg;
    assign slot_width  = sw_reg;
    assign slot_height = sh_reg;

endmodule

// ----- sim/texture_atlas_slab_allocator_tb.sv -----
// Self-checking testbench for the texture atlas slab allocator.
`timescale 1ns / 100ps

module texture_atlas_slab_allocator_tb;
    import tasa_pkg::*;

    localparam int N_PAGES   = DEF_MAX_PAGES;
    localparam int N_SLOTS   = DEF_MAX_SLOTS;
    localparam int N_HANDLES = DEF_MAX_HANDLES;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] hnd;
        logic [ORG_W-1:0]    ox;
        logic [ORG_W-1:0]    oy;
        logic [DIM_W-1:0]    sw;
        logic [DIM_W-1:0]    sh;
    } alloc_result_t;

    // Scoreboard: shadow allocator state plus the queue of expected result items
    class slab_scoreboard;
        int unsigned aw, ah, pw, ph, rw, rh, fmt;
        int unsigned fp_stack[N_PAGES];
        int unsigned fp_cnt;
        int unsigned act_list[N_PAGES];
        int unsigned act_cnt;
        int unsigned org_x[N_PAGES], org_y[N_PAGES];
        int unsigned tex_w[N_PAGES], tex_h[N_PAGES];
        int unsigned slot_tot[N_PAGES], slot_free[N_PAGES];
        int unsigned slot_stk[N_PAGES][N_SLOTS];
        bit          h_valid[N_HANDLES];
        int unsigned h_page[N_HANDLES], h_slot[N_HANDLES];
        int unsigned issued;
        int unsigned fh_stack[N_HANDLES];
        int unsigned fh_cnt;
        int          errors;
        alloc_result_t expected_results[$];

        function new();
            aw = RST_ATLAS_DIM; ah = RST_ATLAS_DIM;
            pw = RST_PAGE_DIM;  ph = RST_PAGE_DIM;
            rw = RST_RSVD_DIM;  rh = RST_RSVD_DIM;
            fmt = RST_FORMAT;
            errors = 0;
            rebuild();
        endfunction

        // Row-major page carve, reserved corner skipped, bindings dropped
        function void rebuild();
            int unsigned xp, yp, skip, oy, start;
            fp_cnt = 0; act_cnt = 0; issued = 0; fh_cnt = 0;
            for (int i = 0; i < N_PAGES; i++)
            begin
                slot_tot[i] = 0; slot_free[i] = 0; tex_w[i] = 0; tex_h[i] = 0;
            end
            for (int i = 0; i < N_HANDLES; i++)
                h_valid[i] = 0;
            if (pw == 0 || ph == 0)
                return;
            xp = aw / pw;
            yp = ah / ph;
            skip = (rw + pw - 1) / pw;
            if (skip > xp)
                skip = xp;
            for (int unsigned i = 0; i < yp && fp_cnt < N_PAGES; i++)
            begin
                oy = i * ph;
                start = (oy < rh) ? skip : 0;
                for (int unsigned j = start; j < xp && fp_cnt < N_PAGES; j++)
                begin
                    org_x[fp_cnt] = j * pw;
                    org_y[fp_cnt] = oy;
                    fp_stack[fp_cnt] = fp_cnt;
                    fp_cnt++;
                end
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ATLAS_W: aw = val;
                REG_ATLAS_H: ah = val;
                REG_PAGE_W:  pw = val;
                REG_PAGE_H:  ph = val;
                REG_RSVD_W:  rw = val;
                REG_RSVD_H:  rh = val;
                REG_FORMAT:  fmt = val[FMT_W-1:0];
                default: return;
            endcase
            rebuild();
        endfunction

        function void slot_pos(int unsigned p, int unsigned s,
                               output logic [ORG_W-1:0] ox, output logic [ORG_W-1:0] oy);
            int unsigned per_row, x, y;
            per_row = (tex_w[p] != 0) ? pw / tex_w[p] : 0;
            if (per_row == 0)
                per_row = 1;
            x = (s % per_row) * tex_w[p] + org_x[p];
            y = (s / per_row) * tex_h[p] + org_y[p];
            ox = x[ORG_W-1:0];
            oy = y[ORG_W-1:0];
        endfunction

        function bit unbind_one(int unsigned h);
            int unsigned p, k;
            if (h >= issued || h >= N_HANDLES || !h_valid[h])
                return 0;
            p = h_page[h];
            if (slot_free[p] < N_SLOTS)
            begin
                slot_stk[p][slot_free[p]] = h_slot[h];
                slot_free[p]++;
            end
            if (fh_cnt < N_HANDLES)
            begin
                fh_stack[fh_cnt] = h;
                fh_cnt++;
            end
            h_valid[h] = 0;
            // emptied page goes back to the free-page stack
            if (slot_free[p] == slot_tot[p])
            begin
                slot_tot[p] = 0;
                slot_free[p] = 0;
                if (fp_cnt < N_PAGES)
                begin
                    fp_stack[fp_cnt] = p;
                    fp_cnt++;
                end
                for (k = 0; k < act_cnt; k++)
                begin
                    if (act_list[k] == p)
                    begin
                        for (; k + 1 < act_cnt; k++)
                            act_list[k] = act_list[k + 1];
                        act_cnt--;
                        break;
                    end
                end
            end
            return 1;
        endfunction

        function alloc_result_t try_bind(int unsigned tw, int unsigned th, int unsigned tf);
            alloc_result_t r;
            int unsigned p, n, s, h;
            bit found;
            r = '{default: '0};
            p = 0; n = 0; found = 0;
            if (tw == 0 || th == 0 || tf != fmt || tw > pw || th > ph)
            begin
                r.status = ST_MISFIT;
                return r;
            end
            for (int unsigned k = 0; k < act_cnt; k++)
            begin
                if (tex_w[act_list[k]] == tw && tex_h[act_list[k]] == th
                    && slot_free[act_list[k]] > 0)
                begin
                    p = act_list[k];
                    found = 1;
                    break;
                end
            end
            if (!found)
            begin
                if (fp_cnt == 0)
                begin
                    r.status = ST_NO_PAGE;
                    return r;
                end
                n = (pw / tw) * (ph / th);
                if (n > N_SLOTS)
                begin
                    r.status = ST_TOO_MANY;
                    return r;
                end
            end
            if (fh_cnt == 0 && issued >= N_HANDLES)
            begin
                r.status = ST_NO_HANDLE;
                return r;
            end
            if (!found)
            begin
                fp_cnt--;
                p = fp_stack[fp_cnt];
                tex_w[p] = tw;
                tex_h[p] = th;
                slot_tot[p] = n;
                slot_free[p] = n;
                for (int unsigned k = 0; k < n; k++)
                    slot_stk[p][k] = n - 1 - k;
                act_list[act_cnt] = p;
                act_cnt++;
            end
            slot_free[p]--;
            s = slot_stk[p][slot_free[p]];
            if (fh_cnt > 0)
            begin
                fh_cnt--;
                h = fh_stack[fh_cnt];
            end
            else
            begin
                h = issued;
                issued++;
            end
            h_valid[h] = 1;
            h_page[h] = p;
            h_slot[h] = s;
            r.status = ST_OK;
            r.hnd = h[HANDLE_W-1:0];
            slot_pos(p, s, r.ox, r.oy);
            r.sw = tw[DIM_W-1:0];
            r.sh = th[DIM_W-1:0];
            return r;
        endfunction

        // Accepted request: work out its result item and queue it
        function void note_request(logic [OP_W-1:0] o, logic [DIM_W-1:0] tw,
                                   logic [DIM_W-1:0] th, logic [FMT_W-1:0] tf,
                                   logic [HANDLE_W-1:0] hd);
            alloc_result_t r;
            int unsigned p;
            r = '{default: '0};
            case (o)
                OP_BIND:   r = try_bind(tw, th, tf);
                OP_UNBIND: r.status = unbind_one(hd) ? ST_OK : ST_BAD_HANDLE;
                OP_LOOKUP:
                begin
                    if (hd < issued && h_valid[hd])
                    begin
                        p = h_page[hd];
                        slot_pos(p, h_slot[hd], r.ox, r.oy);
                        r.sw = tex_w[p][DIM_W-1:0];
                        r.sh = tex_h[p][DIM_W-1:0];
                    end
                    else
                    begin
                        r.status = ST_BAD_HANDLE;
                        r.sw = UNBOUND_SIZE;
                        r.sh = UNBOUND_SIZE;
                    end
                end
                default:
                begin
                    for (int unsigned k = 0; k < issued && k < N_HANDLES; k++)
                        void'(unbind_one(k));
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.hnd !== e.hnd)
            begin
                $error("out_handle: expected %0d, got %0d", e.hnd, got.hnd);
                errors++;
            end
            if (got.ox !== e.ox)
            begin
                $error("origin_x: expected %0d, got %0d", e.ox, got.ox);
                errors++;
            end
            if (got.oy !== e.oy)
            begin
                $error("origin_y: expected %0d, got %0d", e.oy, got.oy);
                errors++;
            end
            if (got.sw !== e.sw)
            begin
                $error("slot_width: expected %0d, got %0d", e.sw, got.sw);
                errors++;
            end
            if (got.sh !== e.sh)
            begin
                $error("slot_height: expected %0d, got %0d", e.sh, got.sh);
                errors++;
            end
        endfunction

        // Mostly a currently bound handle, else any handle
        function logic [HANDLE_W-1:0] pick_handle();
            int unsigned h;
            for (int i = 0; i < 8 && issued > 0; i++)
            begin
                h = $urandom_range(0, issued - 1);
                if (h_valid[h])
                    return h[HANDLE_W-1:0];
            end
            return $urandom_range(0, N_HANDLES - 1);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [OP_W-1:0]       op;
    logic [DIM_W-1:0]      tex_width;
    logic [DIM_W-1:0]      tex_height;
    logic [FMT_W-1:0]      tex_format;
    logic [HANDLE_W-1:0]   handle;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [ORG_W-1:0]      origin_x;
    logic [ORG_W-1:0]      origin_y;
    logic [DIM_W-1:0]      slot_width;
    logic [DIM_W-1:0]      slot_height;

    slab_scoreboard sb;
    bit             quiet;
    int             cycles;

    texture_atlas_slab_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .tex_width(tex_width), .tex_height(tex_height),
        .tex_format(tex_format), .handle(handle),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_handle(out_handle),
        .origin_x(origin_x), .origin_y(origin_y),
        .slot_width(slot_width), .slot_height(slot_height)
    );

    initial clk = 0;
    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("texture_atlas_slab_allocator_tb NOT OK");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{status, out_handle, origin_x, origin_y, slot_width, slot_height});
    end

    // Receiver stalls: a random hold-off before each result item
    initial
    begin
        int n;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] o, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h, input logic [FMT_W-1:0] f,
                             input logic [HANDLE_W-1:0] hd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        op <= o;
        tex_width <= w;
        tex_height <= h;
        tex_format <= f;
        handle <= hd;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(o, w, h, f, hd);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write while idle, then wait out the rebuild
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        drain();
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 0;
        sb.set_reg(idx, val[CFG_DATA_W-1:0]);
        repeat (3) @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic set_atlas(input int unsigned aw, ah, pw, ph, rw, rh, f);
        write_reg(REG_ATLAS_W, aw);
        write_reg(REG_ATLAS_H, ah);
        write_reg(REG_PAGE_W, pw);
        write_reg(REG_PAGE_H, ph);
        write_reg(REG_RSVD_W, rw);
        write_reg(REG_RSVD_H, rh);
        write_reg(REG_FORMAT, f);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim(int unsigned pd);
        int unsigned r, v;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            v = pd >> $urandom_range(0, 4);
            if (v == 0)
                v = 1;
        end
        else if (r < 80)
            v = $urandom_range(1, (pd == 0) ? 1 : pd);
        else if (r < 92)
            v = $urandom_range(0, 4096);
        else
            v = ($urandom_range(0, 1) == 0) ? 0 : 4096;
        return v[DIM_W-1:0];
    endfunction

    task automatic random_items(input int count);
        int unsigned r;
        logic [FMT_W-1:0] f;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : sb.fmt[FMT_W-1:0];
            if (r < 50)
                send_item(OP_BIND, pick_dim(sb.pw), pick_dim(sb.ph), f,
                          $urandom_range(0, N_HANDLES - 1));
            else if (r < 72)
                send_item(OP_UNBIND, $urandom_range(0, 4096), $urandom_range(0, 4096),
                          $urandom_range(0, 15), sb.pick_handle());
            else if (r < 97)
                send_item(OP_LOOKUP, $urandom_range(0, 4096), $urandom_range(0, 4096),
                          $urandom_range(0, 15), sb.pick_handle());
            else
                send_item(OP_ALL, 0, 0, 0, 0);
        end
        quiet = 0;
    endtask

    initial
    begin
        int unsigned cfgs[9][7] = '{
            '{1024, 1024,  256,  256,    0,    0,  0},
            '{4096, 4096,  512,  512, 1024, 1024, 15},
            '{4096, 4096, 4096, 4096,    0,    0,  5},
            '{4096, 4096,    1,    1, 4096, 4096,  9},
            '{ 100,   60,   16,    8,   40,   20,  3},
            '{4096,  300,   64,   32,  200, 4096, 10},
            '{   1,    1, 4096, 4096,    0,    0,  0},
            '{   8,    8,    1,    1,    3,    2,  7},
            '{4096, 4096,   64,   64,    0,    0, 12}
        };
        sb = new();
        quiet = 0;
        cycles = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        op = OP_LOOKUP;
        tex_width = '0;
        tex_height = '0;
        tex_format = '0;
        handle = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1;

        // Directed: bad handles, misfits, too many slots, binds, recycling
        send_item(OP_LOOKUP, 0, 0, 0, 0);
        send_item(OP_UNBIND, 0, 0, 0, 1023);
        send_item(OP_BIND, 0, 16, 0, 0);
        send_item(OP_BIND, 16, 0, 0, 0);
        send_item(OP_BIND, 257, 16, 0, 0);
        send_item(OP_BIND, 16, 16, 15, 0);
        send_item(OP_BIND, 4096, 4096, 0, 0);
        send_item(OP_BIND, 1, 1, 0, 0);
        send_item(OP_BIND, 256, 256, 0, 0);
        send_item(OP_BIND, 16, 16, 0, 0);
        send_item(OP_BIND, 16, 16, 0, 0);
        send_item(OP_BIND, 255, 100, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 0, 1);
        send_item(OP_LOOKUP, 0, 0, 0, 3);
        send_item(OP_LOOKUP, 4096, 4096, 15, 1023);
        send_item(OP_UNBIND, 0, 0, 0, 1);
        send_item(OP_UNBIND, 0, 0, 0, 1);
        send_item(OP_BIND, 16, 16, 0, 0);
        send_item(OP_ALL, 0, 0, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 0, 0);

        // Single page: second size finds no free page
        set_atlas(256, 256, 256, 256, 0, 0, 0);
        send_item(OP_BIND, 8, 8, 0, 0);
        send_item(OP_BIND, 16, 16, 0, 0);
        send_item(OP_ALL, 0, 0, 0, 0);

        // Zero page width: no pages at all
        write_reg(REG_PAGE_W, 0);
        send_item(OP_BIND, 8, 8, 0, 0);

        // Handle exhaustion: four full pages of 256 slots use every handle
        set_atlas(1024, 1024, 256, 256, 0, 0, 0);
        quiet = 1;
        for (int i = 0; i < N_HANDLES + 1; i++)
            send_item(OP_BIND, 16, 16, 0, 0);
        quiet = 0;
        send_item(OP_LOOKUP, 0, 0, 0, 1023);
        send_item(OP_ALL, 0, 0, 0, 0);
        send_item(OP_LOOKUP, 0, 0, 0, 1023);

        // Random phases over a spread of atlas settings
        for (int c = 0; c < 9; c++)
        begin
            set_atlas(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3],
                      cfgs[c][4], cfgs[c][5], cfgs[c][6]);
            random_items(165);
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.expected_results.size() != 0)
        begin
            $error("%0d result items never arrived", sb.expected_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("texture_atlas_slab_allocator_tb OK");
        else
            $display("texture_atlas_slab_allocator_tb NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/tasa_pkg.sv
hdl/tasa_div.sv
hdl/texture_atlas_slab_allocator.sv
sim/texture_atlas_slab_allocator_tb.sv
